FILE: rtl/button_press_classifier_unit_macros.svh
`ifndef BUTTON_PRESS_CLASSIFIER_UNIT_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_UNIT_MACROS_SVH

// same-cycle implication, masked during reset
`define BPC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bpc: check failed");

// next-cycle implication, masked during reset
`define BPC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bpc: check failed");

// next-cycle implication, active during reset
`define BPC_ASSERT_RESET(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("bpc: reset check failed");

`endif

FILE: rtl/bpc_pkg.sv
package bpc_pkg;

   localparam int LEVEL_WIDTH     = 16;
   localparam int INDEX_WIDTH     = 4;
   localparam int REG_WIDTH       = 16;
   localparam int CSR_ADDR_WIDTH  = 4;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam int DEF_NUM_BUTTONS = 16;
   localparam int DEF_COUNT_WIDTH = 16;

   localparam logic [REG_WIDTH-1:0] RST_ENABLE_MASK  = 16'd0;
   localparam logic [REG_WIDTH-1:0] RST_DEBOUNCE     = 16'd50;
   localparam logic [REG_WIDTH-1:0] RST_DOUBLE_PRESS = 16'd300;
   localparam logic [REG_WIDTH-1:0] RST_LONG_PRESS   = 16'd1000;

   typedef enum logic [1:0] {
      KIND_SHORT  = 2'd0,
      KIND_LONG   = 2'd1,
      KIND_DOUBLE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      REG_ENABLE_MASK  = 2'd0,
      REG_DEBOUNCE     = 2'd1,
      REG_DOUBLE_PRESS = 2'd2,
      REG_LONG_PRESS   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [REG_WIDTH-1:0] button_enable_mask;
      logic [REG_WIDTH-1:0] debounce_ticks;
      logic [REG_WIDTH-1:0] double_press_ticks;
      logic [REG_WIDTH-1:0] long_press_ticks;
   } cfg_type;

   typedef struct packed {
      logic                   emit;
      logic [INDEX_WIDTH-1:0] button_index;
      kind_type               press_kind;
   } result_type;

endpackage

FILE: rtl/bpc_req_if.sv
interface bpc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] button_levels;
   logic        event_taken;

   modport source (output valid, output button_levels, output event_taken, input ready);
   modport sink (input valid, input button_levels, input event_taken, output ready);
endinterface

FILE: rtl/bpc_rsp_if.sv
interface bpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] button_index;
   logic [1:0] press_kind;

   modport source (output valid, output button_index, output press_kind, input ready);
   modport sink (input valid, input button_index, input press_kind, output ready);
endinterface

FILE: rtl/button_press_classifier_unit.sv
// Button press classifier.
// req_if carries one tick per item: sampled active-low button levels and the
// event acknowledge bit. rsp_if carries a classified press (button index and
// kind: short, long or double); most ticks produce no item on rsp_if.
// csr_* is an APB-style port for the enable mask and the three delays
// (debounce, double-press window, long-press hold); write only while idle.
// Order: an accepted tick lands in the input register and is classified
// there; its press, if any, is loaded into the result register as the tick
// advances (held back while a result waits), then shows on rsp_if.
// Throughput: one tick per cycle while rsp_if does not stall; the classifier
// state updates in a single pass between the input and result registers.
// Stall: a result waits in the result register while rsp_if.ready is low; the
// input register still takes one tick, and req_if.ready drops only while the
// input register is full and the result register holds a waiting item.
// Reset: registers return to their reset values, all buttons read released,
// timers stop, no event is pending and both channels are empty.
module button_press_classifier_unit #(
   parameter int NUM_BUTTONS = bpc_pkg::DEF_NUM_BUTTONS,
   parameter int COUNT_WIDTH = bpc_pkg::DEF_COUNT_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   bpc_req_if.sink                              req_if,
   bpc_rsp_if.source                            rsp_if,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [bpc_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [bpc_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [bpc_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);
   import bpc_pkg::*;

   cfg_type                cfg_ff;
   reg_index_type          csr_index;
   logic                   csr_write;

   logic                   in_valid_ff;
   logic [LEVEL_WIDTH-1:0] in_levels_ff;
   logic                   in_taken_ff;
   logic                   advance;

   result_type             result;
   logic                   out_valid_ff;
   logic [INDEX_WIDTH-1:0] out_index_ff;
   kind_type               out_kind_ff;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.button_enable_mask <= RST_ENABLE_MASK;
         cfg_ff.debounce_ticks     <= RST_DEBOUNCE;
         cfg_ff.double_press_ticks <= RST_DOUBLE_PRESS;
         cfg_ff.long_press_ticks   <= RST_LONG_PRESS;
      end else if (csr_write) begin
         case (csr_index)
            REG_ENABLE_MASK:  cfg_ff.button_enable_mask <= csr_pwdata[REG_WIDTH-1:0];
            REG_DEBOUNCE:     cfg_ff.debounce_ticks     <= csr_pwdata[REG_WIDTH-1:0];
            REG_DOUBLE_PRESS: cfg_ff.double_press_ticks <= csr_pwdata[REG_WIDTH-1:0];
            REG_LONG_PRESS:   cfg_ff.long_press_ticks   <= csr_pwdata[REG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ENABLE_MASK:  csr_prdata = CSR_DATA_WIDTH'(cfg_ff.button_enable_mask);
         REG_DEBOUNCE:     csr_prdata = CSR_DATA_WIDTH'(cfg_ff.debounce_ticks);
         REG_DOUBLE_PRESS: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.double_press_ticks);
         REG_LONG_PRESS:   csr_prdata = CSR_DATA_WIDTH'(cfg_ff.long_press_ticks);
         default:          csr_prdata = '0;
      endcase
   end

   assign advance      = in_valid_ff & (~out_valid_ff | rsp_if.ready);
   assign req_if.ready = ~in_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_levels_ff <= req_if.button_levels;
         in_taken_ff  <= req_if.event_taken;
      end
   end

   bpc_classify #(
      .NUM_BUTTONS (NUM_BUTTONS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_classify (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .button_levels (in_levels_ff),
      .event_taken   (in_taken_ff),
      .cfg           (cfg_ff),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= result.emit;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.emit) begin
         out_index_ff <= result.button_index;
         out_kind_ff  <= result.press_kind;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.button_index = out_index_ff;
   assign rsp_if.press_kind   = out_kind_ff;

endmodule

FILE: rtl/bpc_classify.sv
module bpc_classify #(
   parameter int NUM_BUTTONS = bpc_pkg::DEF_NUM_BUTTONS,
   parameter int COUNT_WIDTH = bpc_pkg::DEF_COUNT_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic [bpc_pkg::LEVEL_WIDTH-1:0]     button_levels,
   input  logic                                event_taken,
   input  bpc_pkg::cfg_type                    cfg,
   output bpc_pkg::result_type                 result
);
   import bpc_pkg::*;

   localparam int EXT_WIDTH = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;
   localparam logic [EXT_WIDTH-1:0] COUNT_MAX = EXT_WIDTH'((64'd1 << COUNT_WIDTH) - 64'd1);
   localparam logic [LEVEL_WIDTH-1:0] BUTTON_MASK = (NUM_BUTTONS >= LEVEL_WIDTH) ?
      {LEVEL_WIDTH{1'b1}} : LEVEL_WIDTH'((64'd1 << NUM_BUTTONS) - 64'd1);

   function automatic logic [COUNT_WIDTH-1:0] latch_delay(input logic [REG_WIDTH-1:0] value);
      logic [EXT_WIDTH-1:0] ext;
      logic [EXT_WIDTH-1:0] lim;
      ext = EXT_WIDTH'(value);
      if (ext == '0) begin
         lim = EXT_WIDTH'(1);
      end else if (ext > COUNT_MAX) begin
         lim = COUNT_MAX;
      end else begin
         lim = ext;
      end
      return lim[COUNT_WIDTH-1:0];
   endfunction

   logic [LEVEL_WIDTH-1:0] prev_levels_ff, prev_levels_in;
   logic                   deb_busy_ff, deb_busy_in;
   logic [COUNT_WIDTH-1:0] deb_left_ff, deb_left_in;
   logic [INDEX_WIDTH-1:0] deb_btn_ff, deb_btn_in;
   logic [INDEX_WIDTH-1:0] first_btn_ff, first_btn_in;
   logic                   held_ff, held_in;
   logic                   dp_active_ff, dp_active_in;
   logic [COUNT_WIDTH-1:0] dp_left_ff, dp_left_in;
   logic                   lp_active_ff, lp_active_in;
   logic [COUNT_WIDTH-1:0] lp_left_ff, lp_left_in;
   logic                   pending_ff, pending_in;

   logic [LEVEL_WIDTH-1:0] changed;
   logic [INDEX_WIDTH-1:0] low_idx;
   logic                   high;

   assign changed = (button_levels ^ prev_levels_ff) & cfg.button_enable_mask & BUTTON_MASK;

   always_comb begin
      low_idx = '0;
      for (int i = LEVEL_WIDTH - 1; i >= 0; i--) begin
         if (changed[i]) begin
            low_idx = INDEX_WIDTH'(i);
         end
      end
   end

   always_comb begin
      prev_levels_in = button_levels;
      deb_busy_in    = deb_busy_ff;
      deb_left_in    = deb_left_ff;
      deb_btn_in     = deb_btn_ff;
      first_btn_in   = first_btn_ff;
      held_in        = held_ff;
      dp_active_in   = dp_active_ff;
      dp_left_in     = dp_left_ff;
      lp_active_in   = lp_active_ff;
      lp_left_in     = lp_left_ff;
      pending_in     = pending_ff & ~event_taken;
      result.emit         = 1'b0;
      result.button_index = first_btn_ff;
      result.press_kind   = KIND_SHORT;
      high = button_levels[deb_btn_ff];

      if (lp_active_ff) begin
         if (lp_left_ff != '0) begin
            lp_left_in = lp_left_ff - 1'b1;
         end
         if (lp_left_in == '0) begin
            lp_active_in = 1'b0;
         end
      end

      if (dp_active_ff) begin
         if (dp_left_ff != '0) begin
            dp_left_in = dp_left_ff - 1'b1;
         end
         if (dp_left_in == '0) begin
            dp_active_in = 1'b0;
            if (!pending_in) begin
               pending_in          = 1'b1;
               result.emit         = 1'b1;
               result.button_index = first_btn_ff;
               result.press_kind   = KIND_SHORT;
            end
         end
      end

      if (deb_busy_ff) begin
         if (deb_left_ff != '0) begin
            deb_left_in = deb_left_ff - 1'b1;
         end
         if (deb_left_in == '0) begin
            deb_busy_in = 1'b0;
            if (!pending_in) begin
               if (!held_ff) begin
                  if (high) begin
                     if (dp_active_in) begin
                        if (deb_btn_ff == first_btn_ff) begin
                           dp_active_in        = 1'b0;
                           pending_in          = 1'b1;
                           result.emit         = 1'b1;
                           result.button_index = first_btn_ff;
                           result.press_kind   = KIND_DOUBLE;
                        end
                     end else begin
                        dp_active_in = 1'b1;
                        dp_left_in   = latch_delay(cfg.double_press_ticks);
                        first_btn_in = deb_btn_ff;
                     end
                  end else begin
                     lp_active_in = 1'b1;
                     lp_left_in   = latch_delay(cfg.long_press_ticks);
                     first_btn_in = deb_btn_ff;
                     held_in      = 1'b1;
                  end
               end else if (high && deb_btn_ff == first_btn_ff) begin
                  result.press_kind   = lp_active_in ? KIND_SHORT : KIND_LONG;
                  lp_active_in        = 1'b0;
                  held_in             = 1'b0;
                  pending_in          = 1'b1;
                  result.emit         = 1'b1;
                  result.button_index = first_btn_ff;
               end
            end
         end
      end

      if (!deb_busy_in && !pending_in && changed != '0) begin
         deb_btn_in  = low_idx;
         deb_busy_in = 1'b1;
         deb_left_in = latch_delay(cfg.debounce_ticks);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_levels_ff <= '1;
         deb_busy_ff    <= 1'b0;
         deb_left_ff    <= '0;
         deb_btn_ff     <= '0;
         first_btn_ff   <= '0;
         held_ff        <= 1'b0;
         dp_active_ff   <= 1'b0;
         dp_left_ff     <= '0;
         lp_active_ff   <= 1'b0;
         lp_left_ff     <= '0;
         pending_ff     <= 1'b0;
      end else if (advance) begin
         prev_levels_ff <= prev_levels_in;
         deb_busy_ff    <= deb_busy_in;
         deb_left_ff    <= deb_left_in;
         deb_btn_ff     <= deb_btn_in;
         first_btn_ff   <= first_btn_in;
         held_ff        <= held_in;
         dp_active_ff   <= dp_active_in;
         dp_left_ff     <= dp_left_in;
         lp_active_ff   <= lp_active_in;
         lp_left_ff     <= lp_left_in;
         pending_ff     <= pending_in;
      end
   end

endmodule

FILE: rtl/bpc_checker.sv
`include "button_press_classifier_unit_macros.svh"

module bpc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_button_index,
   input logic [1:0] rsp_press_kind
);
   import bpc_pkg::*;

   `BPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_button_index) && $stable(rsp_press_kind))

   `BPC_ASSERT_NOW(a_kind_legal, rsp_valid,
      rsp_press_kind == KIND_SHORT || rsp_press_kind == KIND_LONG ||
      rsp_press_kind == KIND_DOUBLE)

   `BPC_ASSERT_RESET(a_reset_rsp_empty, reset, !rsp_valid)

   `BPC_ASSERT_RESET(a_reset_req_open, reset, req_ready)

   `BPC_ASSERT_NOW(a_ready_when_out_free, !rsp_valid || rsp_ready, req_ready)

endmodule

bind button_press_classifier_unit bpc_checker u_bpc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_button_index (rsp_if.button_index),
   .rsp_press_kind   (rsp_if.press_kind)
);
